// ----- rtl/acdd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// acdd_pkg
// Shared types and codes for the animation channel delta decompressor.
// ----------------------------------------------------------------------------
package acdd_pkg;

    // transaction function codes
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_PUSH  = 2'd1;
    localparam logic [1:0] FUNC_PULL  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NEED     = 2'd1;
    localparam logic [1:0] ST_NOSTREAM = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // decode modes
    localparam logic [1:0] MODE_ZERO  = 2'd0;
    localparam logic [1:0] MODE_SAME  = 2'd1;
    localparam logic [1:0] MODE_KEYS  = 2'd2;
    localparam logic [1:0] MODE_DELTA = 2'd3;

    // stream phase
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_RUN    = 2'd2;

    // header opcodes with a fixed meaning
    localparam logic [3:0] OP_ZERO = 4'h0;
    localparam logic [3:0] OP_SAME = 4'hE;
    localparam logic [3:0] OP_KEYS = 4'hF;

    localparam int DELTA_W = 17;

    // byte queue control
    typedef struct packed {
        logic       push;
        logic [7:0] data;
        logic [1:0] pop;
        logic       clear;
    } t_q_ctrl;

endpackage
`default_nettype wire

// ----- rtl/acdd_divider.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// acdd_divider
// Restoring signed divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module acdd_divider (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_start,
    input  wire logic signed [acdd_pkg::DELTA_W-1:0]  i_dividend,
    input  wire logic        [4:0]                    i_divisor,
    output logic                                      o_done,
    output logic signed [acdd_pkg::DELTA_W-1:0]       o_quotient
);
    localparam int W = acdd_pkg::DELTA_W;

    logic [W-1:0] r_quo, n_quo;
    logic [3:0]   r_rem, n_rem;
    logic [4:0]   r_div, n_div;
    logic [4:0]   r_cnt, n_cnt;
    logic         r_neg, n_neg;
    logic         r_busy, n_busy;
    logic         r_done, n_done;
    logic [4:0]   rem2;

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_div  = r_div;
        n_cnt  = r_cnt;
        n_neg  = r_neg;
        n_busy = r_busy;
        n_done = 1'b0;
        rem2   = {r_rem, r_quo[W-1]};
        if (i_start) begin
            n_neg  = i_dividend[W-1];
            n_quo  = i_dividend[W-1] ? W'(-i_dividend) : W'(i_dividend);
            n_rem  = '0;
            n_div  = i_divisor;
            n_cnt  = 5'(W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (rem2 >= r_div) begin
                n_rem = 4'(rem2 - r_div);
                n_quo = {r_quo[W-2:0], 1'b1};
            end else begin
                n_rem = rem2[3:0];
                n_quo = {r_quo[W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
        r_neg <= n_neg;
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? $signed(W'(-r_quo)) : $signed(r_quo);

endmodule
`default_nettype wire

// ----- rtl/acdd_byte_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// acdd_byte_queue
// Source byte FIFO; head three bytes visible, pops up to three at once.
// ----------------------------------------------------------------------------
module acdd_byte_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire acdd_pkg::t_q_ctrl          i_ctrl,
    output logic [$clog2(DEPTH+1)-1:0]      o_count,
    output logic [7:0]                      o_byte0,
    output logic [7:0]                      o_byte1,
    output logic [7:0]                      o_byte2
);
    localparam int CW = $clog2(DEPTH+1);

    logic [7:0]    r_q [DEPTH];
    logic [CW-1:0] r_count;
    logic [1:0]    pop_eff;

    // pop never takes more than is queued
    assign pop_eff = (CW'(i_ctrl.pop) > r_count) ? r_count[1:0] : i_ctrl.pop;

    for (genvar g = 0; g < DEPTH; g++) begin : g_slot
        localparam int G1 = (g + 1 < DEPTH) ? g + 1 : g;
        localparam int G2 = (g + 2 < DEPTH) ? g + 2 : g;
        localparam int G3 = (g + 3 < DEPTH) ? g + 3 : g;
        always_ff @(posedge i_clk) begin
            if (i_ctrl.push && r_count == CW'(g)) begin
                r_q[g] <= i_ctrl.data;
            end else begin
                unique case (pop_eff)
                    2'd1:    r_q[g] <= r_q[G1];
                    2'd2:    r_q[g] <= r_q[G2];
                    2'd3:    r_q[g] <= r_q[G3];
                    default: r_q[g] <= r_q[g];
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_count <= '0;
        end else if (i_ctrl.push) begin
            r_count <= r_count + CW'(1);
        end else begin
            r_count <= r_count - CW'(pop_eff);
        end
    end

    assign o_count  = r_count;
    assign o_byte0  = (r_count > CW'(0)) ? r_q[0] : 8'd0;
    assign o_byte1  = (r_count > CW'(1)) ? r_q[1] : 8'd0;
    assign o_byte2  = (r_count > CW'(2)) ? r_q[2] : 8'd0;

endmodule
`default_nettype wire

// ----- rtl/anim_channel_delta_decompressor_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// anim_channel_delta_decompressor_unit
// Decodes one compressed stream of 16-bit animation samples.
// ----------------------------------------------------------------------------
// A start transaction opens a stream (length, destination stride); push
// transactions feed source bytes into a small queue; each pull returns the
// next sample or a status saying why it cannot. The block takes one
// transaction at a time. A pull that lands inside an interpolated segment
// waits on the restoring divider, which forms delta / segment length one
// quotient bit per cycle. The result register frees the input side: a new
// transaction is accepted while the previous result still waits downstream.
// Header low nibble: 0 zero fill, 14 repeat value, 15 raw 16-bit keys,
// 1..13 packed signed deltas of nibble+1 bits, MSB first.
// ----------------------------------------------------------------------------
module anim_channel_delta_decompressor_unit #(
    parameter int BYTE_QUEUE_DEPTH = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input channel
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_func,
    input  wire logic [7:0]         i_data_byte,
    input  wire logic [15:0]        i_stream_length,
    input  wire logic [7:0]         i_step_size,
    // result channel
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [1:0]              o_status,
    output logic signed [15:0]      o_sample,
    output logic [23:0]             o_dest_offset,
    output logic                    o_last_sample,
    output logic [17:0]             o_bytes_used
);
    localparam int CW = $clog2(BYTE_QUEUE_DEPTH+1);
    localparam int DW = acdd_pkg::DELTA_W;

    typedef enum logic [4:0] {
        S_READY = 5'b00001,
        S_EXEC  = 5'b00010,
        S_DIV   = 5'b00100,
        S_FIN   = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // latched transaction
    logic [1:0]  r_func, n_func;
    logic [7:0]  r_data, n_data;
    logic [15:0] r_len, n_len;
    logic [7:0]  r_stp, n_stp;

    // stream state
    logic [1:0]          r_mode, n_mode;
    logic [4:0]          r_dbits, n_dbits;
    logic [4:0]          r_isteps, n_isteps;
    logic [15:0]         r_run, n_run;
    logic [15:0]         r_base, n_base;
    logic signed [DW-1:0] r_sdelta, n_sdelta;
    logic [4:0]          r_sstep, n_sstep;
    logic [4:0]          r_slen, n_slen;
    logic [15:0]         r_left, n_left;
    logic [15:0]         r_index, n_index;
    logic [2:0]          r_boff, n_boff;
    logic [1:0]          r_phase, n_phase;
    logic [7:0]          r_stride, n_stride;
    logic [17:0]         r_btotal, n_btotal;
    logic [15:0]         r_value, n_value;
    logic                r_is_run, n_is_run;

    // staged result
    logic [1:0]  r_rstat, n_rstat;
    logic [15:0] r_rsmp, n_rsmp;
    logic [23:0] r_rdest, n_rdest;
    logic        r_rlast, n_rlast;
    logic [17:0] r_rused, n_rused;

    // output register
    logic        r_ovalid, n_ovalid;
    logic [1:0]  r_ostat, n_ostat;
    logic [15:0] r_osmp, n_osmp;
    logic [23:0] r_odest, n_odest;
    logic        r_olast, n_olast;
    logic [17:0] r_oused, n_oused;

    // queue and divider
    acdd_pkg::t_q_ctrl q_ctrl;
    logic [CW-1:0] q_count;
    logic [7:0]    qb0, qb1, qb2;
    logic          div_start, div_done;
    logic signed [DW-1:0] div_quot;

    logic accept, out_free;

    // decode helpers
    logic [3:0]  op;
    logic [1:0]  hdr_need;
    logic [15:0] hdr_val;
    logic [5:0]  bit_sum;
    logic [1:0]  d_need, d_pop;
    logic [23:0] win_sh;
    logic signed [23:0] win_s;
    logic signed [DW-1:0] d_val, k_val;
    logic [15:0] key;
    logic [4:0]  n_plus, seg_new;
    logic        load;
    logic [4:0]  eff_len, eff_step, kk;
    logic signed [DW-1:0] eff_delta;
    logic [15:0] eff_base;
    logic [15:0] new_left, new_index;
    logic        pad;

    acdd_byte_queue #(.DEPTH(BYTE_QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (q_ctrl),
        .o_count (q_count),
        .o_byte0 (qb0),
        .o_byte1 (qb1),
        .o_byte2 (qb2)
    );

    acdd_divider u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(eff_delta),
        .i_divisor (eff_len),
        .o_done    (div_done),
        .o_quotient(div_quot)
    );

    assign o_in_stall = (r_state != S_READY);
    assign accept     = i_in_valid && !o_in_stall;
    assign out_free   = !r_ovalid || !i_out_stall;

    // header fields
    assign op       = qb0[3:0];
    assign hdr_need = (op == acdd_pkg::OP_ZERO) ? 2'd1 : 2'd3;
    assign hdr_val  = (op == acdd_pkg::OP_ZERO) ? 16'd0 : {qb2, qb1};

    // packed delta: align window at the bit offset, sign-extend the top field
    assign bit_sum = 6'({3'd0, r_boff}) + 6'({1'b0, r_dbits});
    assign d_need  = 2'((bit_sum + 6'd7) >> 3);
    assign d_pop   = 2'(bit_sum >> 3);
    assign win_sh  = {qb0, qb1, qb2} << r_boff;
    assign win_s   = $signed(win_sh) >>> (5'd24 - r_dbits);
    assign d_val   = win_s[DW-1:0];

    // raw key difference
    assign key   = {qb1, qb0};
    assign k_val = $signed({key[15], key}) - $signed({r_run[15], r_run});

    // segment setup
    assign n_plus  = r_isteps + 5'd1;
    assign seg_new = (r_left >= 16'(n_plus)) ? n_plus : r_left[4:0];
    assign load    = (r_slen == 5'd0);
    assign eff_len   = load ? seg_new : r_slen;
    assign eff_step  = load ? 5'd0 : r_sstep;
    assign eff_base  = load ? r_run : r_base;
    assign eff_delta = load ? ((r_mode == acdd_pkg::MODE_KEYS) ? k_val : d_val) : r_sdelta;
    assign kk        = eff_step + 5'd1;

    assign new_left  = r_left - 16'd1;
    assign new_index = r_is_run ? r_index + 16'd1 : r_index;
    assign pad       = (new_left == 16'd0) && (r_mode == acdd_pkg::MODE_DELTA)
                       && (r_boff != 3'd0);

    always_comb begin
        n_state  = r_state;
        n_func   = r_func;
        n_data   = r_data;
        n_len    = r_len;
        n_stp    = r_stp;
        n_mode   = r_mode;
        n_dbits  = r_dbits;
        n_isteps = r_isteps;
        n_run    = r_run;
        n_base   = r_base;
        n_sdelta = r_sdelta;
        n_sstep  = r_sstep;
        n_slen   = r_slen;
        n_left   = r_left;
        n_index  = r_index;
        n_boff   = r_boff;
        n_phase  = r_phase;
        n_stride = r_stride;
        n_btotal = r_btotal;
        n_value  = r_value;
        n_is_run = r_is_run;
        n_rstat  = r_rstat;
        n_rsmp   = r_rsmp;
        n_rdest  = r_rdest;
        n_rlast  = r_rlast;
        n_rused  = r_rused;
        n_ovalid = r_ovalid && i_out_stall;
        n_ostat  = r_ostat;
        n_osmp   = r_osmp;
        n_odest  = r_odest;
        n_olast  = r_olast;
        n_oused  = r_oused;
        q_ctrl   = '0;
        q_ctrl.data = r_data;
        div_start = 1'b0;

        unique case (r_state)
            S_READY: begin
                if (accept) begin
                    n_func  = i_func;
                    n_data  = i_data_byte;
                    n_len   = i_stream_length;
                    n_stp   = i_step_size;
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                // status-only result unless a sample path overrides
                n_rsmp  = '0;
                n_rdest = '0;
                n_rlast = 1'b0;
                n_rused = '0;
                n_state = S_READY;
                if (r_func == acdd_pkg::FUNC_START) begin
                    n_mode   = acdd_pkg::MODE_ZERO;
                    n_dbits  = '0;
                    n_isteps = '0;
                    n_run    = '0;
                    n_base   = '0;
                    n_sdelta = '0;
                    n_sstep  = '0;
                    n_slen   = '0;
                    n_index  = '0;
                    n_boff   = '0;
                    n_btotal = '0;
                    n_stride = r_stp;
                    n_left   = r_len;
                    n_phase  = (r_len != 16'd0) ? acdd_pkg::PH_HEADER : acdd_pkg::PH_IDLE;
                    q_ctrl.clear = 1'b1;
                end else if (r_func == acdd_pkg::FUNC_PUSH) begin
                    if (r_phase == acdd_pkg::PH_IDLE) begin
                        n_rstat = acdd_pkg::ST_NOSTREAM;
                        n_state = S_EMIT;
                    end else if (q_count >= CW'(BYTE_QUEUE_DEPTH)) begin
                        n_rstat = acdd_pkg::ST_OVERFLOW;
                        n_state = S_EMIT;
                    end else begin
                        q_ctrl.push = 1'b1;
                    end
                end else if (r_func == acdd_pkg::FUNC_PULL) begin
                    if (r_phase == acdd_pkg::PH_IDLE) begin
                        n_rstat = acdd_pkg::ST_NOSTREAM;
                        n_state = S_EMIT;
                    end else if (r_phase == acdd_pkg::PH_HEADER) begin
                        if (q_count == CW'(0) || q_count < CW'(hdr_need)) begin
                            n_rstat = acdd_pkg::ST_NEED;
                            n_state = S_EMIT;
                        end else begin
                            priority if (op == acdd_pkg::OP_ZERO) n_mode = acdd_pkg::MODE_ZERO;
                            else if (op == acdd_pkg::OP_SAME) n_mode = acdd_pkg::MODE_SAME;
                            else if (op == acdd_pkg::OP_KEYS) n_mode = acdd_pkg::MODE_KEYS;
                            else n_mode = acdd_pkg::MODE_DELTA;
                            n_dbits  = 5'({1'b0, op}) + 5'd1;
                            n_isteps = {1'b0, qb0[7:4]};
                            q_ctrl.pop = hdr_need;
                            n_btotal = r_btotal + 18'(hdr_need);
                            n_run    = hdr_val;
                            n_base   = hdr_val;
                            n_value  = hdr_val;
                            n_sdelta = '0;
                            n_sstep  = '0;
                            n_slen   = '0;
                            n_boff   = '0;
                            n_index  = '0;
                            n_phase  = acdd_pkg::PH_RUN;
                            n_is_run = 1'b0;
                            n_state  = S_FIN;
                        end
                    end else if (r_mode == acdd_pkg::MODE_KEYS ||
                                 r_mode == acdd_pkg::MODE_DELTA) begin
                        n_is_run = 1'b1;
                        if (load && r_mode == acdd_pkg::MODE_KEYS && q_count < CW'(2)) begin
                            n_rstat = acdd_pkg::ST_NEED;
                            n_state = S_EMIT;
                        end else if (load && r_mode == acdd_pkg::MODE_DELTA &&
                                     q_count < CW'(d_need)) begin
                            n_rstat = acdd_pkg::ST_NEED;
                            n_state = S_EMIT;
                        end else begin
                            if (load) begin
                                if (r_mode == acdd_pkg::MODE_KEYS) begin
                                    q_ctrl.pop = 2'd2;
                                    n_btotal   = r_btotal + 18'd2;
                                end else begin
                                    q_ctrl.pop = d_pop;
                                    n_btotal   = r_btotal + 18'(d_pop);
                                    n_boff     = bit_sum[2:0];
                                end
                                n_sdelta = eff_delta;
                                n_base   = eff_base;
                            end
                            if (kk >= eff_len) begin
                                // segment end lands exactly on base + delta
                                n_value = eff_base + 16'(eff_delta);
                                n_run   = eff_base + 16'(eff_delta);
                                n_slen  = '0;
                                n_sstep = '0;
                                n_state = S_FIN;
                            end else begin
                                n_slen    = eff_len;
                                n_sstep   = kk;
                                div_start = 1'b1;
                                n_state   = S_DIV;
                            end
                        end
                    end else begin
                        n_is_run = 1'b1;
                        n_value  = (r_mode == acdd_pkg::MODE_ZERO) ? 16'd0 : r_run;
                        n_state  = S_FIN;
                    end
                end
            end

            S_DIV: begin
                if (div_done) begin
                    n_value = r_run + 16'(div_quot);
                    n_run   = r_run + 16'(div_quot);
                    n_state = S_FIN;
                end
            end

            S_FIN: begin
                n_index = new_index;
                n_left  = new_left;
                n_rstat = acdd_pkg::ST_OK;
                n_rsmp  = r_value;
                n_rdest = 24'(new_index) * 24'(r_stride);
                n_rlast = (new_left == 16'd0);
                n_rused = '0;
                if (new_left == 16'd0) begin
                    // close the stream; a partly used delta byte goes too
                    if (pad) begin
                        q_ctrl.pop = 2'd1;
                        n_boff     = '0;
                    end
                    n_phase = acdd_pkg::PH_IDLE;
                    n_rused = r_btotal + ((pad && q_count != CW'(0)) ? 18'd1 : 18'd0);
                    n_btotal = n_rused;
                end
                n_state = S_EMIT;
            end

            S_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ostat  = r_rstat;
                    n_osmp   = r_rsmp;
                    n_odest  = r_rdest;
                    n_olast  = r_rlast;
                    n_oused  = r_rused;
                    n_state  = S_READY;
                end
            end

            default: n_state = S_READY;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_READY;
            r_mode   <= acdd_pkg::MODE_ZERO;
            r_dbits  <= '0;
            r_isteps <= '0;
            r_run    <= '0;
            r_base   <= '0;
            r_sdelta <= '0;
            r_sstep  <= '0;
            r_slen   <= '0;
            r_left   <= '0;
            r_index  <= '0;
            r_boff   <= '0;
            r_phase  <= acdd_pkg::PH_IDLE;
            r_stride <= 8'd1;
            r_btotal <= '0;
            r_is_run <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mode   <= n_mode;
            r_dbits  <= n_dbits;
            r_isteps <= n_isteps;
            r_run    <= n_run;
            r_base   <= n_base;
            r_sdelta <= n_sdelta;
            r_sstep  <= n_sstep;
            r_slen   <= n_slen;
            r_left   <= n_left;
            r_index  <= n_index;
            r_boff   <= n_boff;
            r_phase  <= n_phase;
            r_stride <= n_stride;
            r_btotal <= n_btotal;
            r_is_run <= n_is_run;
            r_ovalid <= n_ovalid;
        end
        r_func  <= n_func;
        r_data  <= n_data;
        r_len   <= n_len;
        r_stp   <= n_stp;
        r_value <= n_value;
        r_rstat <= n_rstat;
        r_rsmp  <= n_rsmp;
        r_rdest <= n_rdest;
        r_rlast <= n_rlast;
        r_rused <= n_rused;
        r_ostat <= n_ostat;
        r_osmp  <= n_osmp;
        r_odest <= n_odest;
        r_olast <= n_olast;
        r_oused <= n_oused;
    end

    assign o_out_valid   = r_ovalid;
    assign o_status      = r_ostat;
    assign o_sample      = $signed(r_osmp);
    assign o_dest_offset = r_odest;
    assign o_last_sample = r_olast;
    assign o_bytes_used  = r_oused;

    // a staged result that finds the output free is shown next cycle
    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free) |=> o_out_valid)
        else $error("staged result not loaded into output register");

    // queue never holds more than its depth
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= CW'(BYTE_QUEUE_DEPTH))
        else $error("byte queue count exceeds depth");

    // divider finishes only while the sequencer waits on it
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("divider done outside divide state");

    // the last sample is always a good sample
    a_last_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_sample) |-> o_status == acdd_pkg::ST_OK)
        else $error("last sample flagged on a status result");

endmodule
`default_nettype wire

// ----- tb/sv/anim_channel_delta_decompressor_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// anim_channel_delta_decompressor_unit_tb
// Self-checking bench for the animation channel delta decompressor.
// ----------------------------------------------------------------------------
// Directed streams in every header mode, plus the special cases, followed by
// random streams. Each transaction's expected result comes from a behavioral
// decoder in this file. A queue-fed driver and a monitor both idle at random.
// ----------------------------------------------------------------------------
module anim_channel_delta_decompressor_unit_tb;

    localparam int QDEPTH = 4;
    localparam logic [1:0] FUNC_NONE = 2'd3;  // unused code, ignored by the block

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  data;
        logic [15:0] len;
        logic [7:0]  step;
    } t_txn;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [15:0] sample;
        logic [23:0]        offset;
        logic               last;
        logic [17:0]        used;
    } t_sample_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [1:0]  i_func = acdd_pkg::FUNC_START;
    logic [7:0]  i_data_byte = '0;
    logic [15:0] i_stream_length = '0;
    logic [7:0]  i_step_size = '0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall, o_out_valid, o_last_sample;
    logic [1:0]  o_status;
    logic signed [15:0] o_sample;
    logic [23:0] o_dest_offset;
    logic [17:0] o_bytes_used;

    anim_channel_delta_decompressor_unit #(.BYTE_QUEUE_DEPTH(QDEPTH)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_func(i_func), .i_data_byte(i_data_byte),
        .i_stream_length(i_stream_length), .i_step_size(i_step_size),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_status(o_status), .o_sample(o_sample), .o_dest_offset(o_dest_offset),
        .o_last_sample(o_last_sample), .o_bytes_used(o_bytes_used)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Decoder state, advanced as transactions are queued. The driver
    // sends them in the same order, so predictions line up with results.
    // ------------------------------------------------------------------
    logic [1:0]  dec_mode, dec_phase;
    logic [4:0]  dec_bits, dec_isteps, dec_seg_pos, dec_seg_len;
    logic [2:0]  dec_bit_off;
    logic [2:0]  dec_qcnt;
    logic [7:0]  dec_q [QDEPTH];
    logic [7:0]  dec_stride;
    logic [15:0] dec_run, dec_base, dec_left, dec_index;
    int          dec_delta;
    logic [17:0] dec_total;

    t_txn        pending_txns[$];
    t_sample_res expected_samples[$];
    int          mismatches = 0;
    int          cycle_cnt = 0;
    bit          stim_done = 1'b0;

    task automatic clear_decoder();
        dec_mode = acdd_pkg::MODE_ZERO; dec_phase = acdd_pkg::PH_IDLE;
        dec_bits = '0; dec_isteps = '0; dec_seg_pos = '0; dec_seg_len = '0;
        dec_bit_off = '0; dec_qcnt = '0; dec_stride = 8'd1;
        dec_run = '0; dec_base = '0; dec_left = '0; dec_index = '0;
        dec_delta = 0; dec_total = '0;
        for (int i = 0; i < QDEPTH; i++) dec_q[i] = '0;
    endtask

    function automatic logic [7:0] qbyte(int i);
        return (i < int'(dec_qcnt)) ? dec_q[i] : 8'd0;
    endfunction

    task automatic qpop(int k);
        if (k > int'(dec_qcnt)) k = int'(dec_qcnt);
        for (int i = 0; i < QDEPTH; i++) dec_q[i] = (i + k < QDEPTH) ? dec_q[i + k] : 8'd0;
        dec_qcnt = 3'(int'(dec_qcnt) - k);
        dec_total = 18'(int'(dec_total) + k);
    endtask

    task automatic post_status(logic [1:0] st);
        expected_samples.push_back('{st, 16'sd0, 24'd0, 1'b0, 18'd0});
    endtask

    // Advance the decoder by one transaction and queue its result, if any.
    task automatic decode_txn(t_txn t);
        logic [15:0] val;
        logic [3:0]  op;
        logic [7:0]  hb;
        int          need, n;
        logic [23:0] w;
        int          raw;
        case (t.func)
            acdd_pkg::FUNC_START: begin
                clear_decoder();
                dec_stride = t.step;
                dec_left = t.len;
                dec_phase = (t.len != 0) ? acdd_pkg::PH_HEADER : acdd_pkg::PH_IDLE;
                return;
            end
            FUNC_NONE: return;
            acdd_pkg::FUNC_PUSH: begin
                if (dec_phase == acdd_pkg::PH_IDLE) post_status(acdd_pkg::ST_NOSTREAM);
                else if (dec_qcnt >= QDEPTH) post_status(acdd_pkg::ST_OVERFLOW);
                else begin
                    dec_q[dec_qcnt] = t.data;
                    dec_qcnt++;
                end
                return;
            end
            default: ;
        endcase
        // pull
        if (dec_phase == acdd_pkg::PH_IDLE) begin
            post_status(acdd_pkg::ST_NOSTREAM);
            return;
        end
        if (dec_phase == acdd_pkg::PH_HEADER) begin
            hb = qbyte(0);
            op = hb[3:0];
            need = (op == acdd_pkg::OP_ZERO) ? 1 : 3;
            if (dec_qcnt < need) begin
                post_status(acdd_pkg::ST_NEED);
                return;
            end
            if (op == acdd_pkg::OP_ZERO) dec_mode = acdd_pkg::MODE_ZERO;
            else if (op == acdd_pkg::OP_SAME) dec_mode = acdd_pkg::MODE_SAME;
            else if (op == acdd_pkg::OP_KEYS) dec_mode = acdd_pkg::MODE_KEYS;
            else dec_mode = acdd_pkg::MODE_DELTA;
            dec_bits = {1'b0, op} + 5'd1;
            dec_isteps = {1'b0, hb[7:4]};
            val = (op == acdd_pkg::OP_ZERO) ? 16'd0 : {qbyte(2), qbyte(1)};
            qpop(need);
            dec_run = val; dec_base = val; dec_delta = 0;
            dec_seg_pos = '0; dec_seg_len = '0; dec_bit_off = '0; dec_index = '0;
            dec_left--;
            dec_phase = acdd_pkg::PH_RUN;
        end else begin
            if (dec_mode == acdd_pkg::MODE_KEYS || dec_mode == acdd_pkg::MODE_DELTA) begin
                if (dec_seg_len == 0) begin
                    n = dec_isteps + 1;
                    if (dec_mode == acdd_pkg::MODE_KEYS) begin
                        if (dec_qcnt < 2) begin
                            post_status(acdd_pkg::ST_NEED);
                            return;
                        end
                        dec_delta = int'($signed({qbyte(1), qbyte(0)})) - int'($signed(dec_run));
                        qpop(2);
                    end else begin
                        need = (dec_bit_off + dec_bits + 7) >> 3;
                        if (dec_qcnt < need) begin
                            post_status(acdd_pkg::ST_NEED);
                            return;
                        end
                        w = {qbyte(0), qbyte(1), qbyte(2)};
                        raw = int'((w >> (24 - dec_bit_off - dec_bits)) & ((24'd1 << dec_bits) - 1));
                        dec_delta = raw;
                        if (raw & (1 << (dec_bits - 1))) dec_delta -= (1 << dec_bits);
                        qpop((dec_bit_off + dec_bits) >> 3);
                        dec_bit_off = dec_bit_off + dec_bits[2:0];
                    end
                    dec_seg_len = (dec_left >= n) ? n[4:0] : dec_left[4:0];
                    dec_base = dec_run;
                    dec_seg_pos = '0;
                end
                if (dec_seg_pos + 1 >= dec_seg_len) begin
                    // closing sample of a segment lands exactly on base + delta
                    val = dec_base + dec_delta[15:0];
                    dec_seg_len = '0;
                    dec_seg_pos = '0;
                end else begin
                    val = dec_run + 16'(dec_delta / int'(dec_seg_len));
                    dec_seg_pos++;
                end
                dec_run = val;
            end else begin
                val = (dec_mode == acdd_pkg::MODE_ZERO) ? 16'd0 : dec_run;
            end
            dec_index++;
            dec_left--;
        end
        if (dec_left == 0) begin
            // partly used byte after the last delta counts as consumed
            if (dec_mode == acdd_pkg::MODE_DELTA && dec_bit_off != 0) begin
                qpop(1);
                dec_bit_off = '0;
            end
            dec_phase = acdd_pkg::PH_IDLE;
            expected_samples.push_back('{acdd_pkg::ST_OK, val,
                                         24'(dec_index) * 24'(dec_stride), 1'b1,
                                         dec_total});
        end else begin
            expected_samples.push_back('{acdd_pkg::ST_OK, val,
                                         24'(dec_index) * 24'(dec_stride), 1'b0,
                                         18'd0});
        end
    endtask

    task automatic add_txn(logic [1:0] f, logic [7:0] d, logic [15:0] l, logic [7:0] s);
        t_txn t;
        t = '{f, d, l, s};
        pending_txns.push_back(t);
        decode_txn(t);
    endtask

    // Random stream: mostly well-formed push/pull traffic, some noise.
    task automatic random_stream(ref int budget);
        logic [15:0] len;
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) len = 16'($urandom);                 // long; dropped by next start
        else if (r < 15) len = 16'($urandom_range(60, 300));
        else len = 16'($urandom_range(1, 24));
        r = $urandom_range(0, 99);
        add_txn(acdd_pkg::FUNC_START, 8'($urandom), len,
                (r < 5) ? 8'd0 : (r < 10) ? 8'd255 : 8'($urandom_range(1, 255)));
        budget--;
        while (dec_phase != acdd_pkg::PH_IDLE && budget > 0) begin
            r = $urandom_range(0, 99);
            if (r < 3) add_txn(FUNC_NONE, 8'($urandom), 16'($urandom), 8'($urandom));
            else if (r < 6)
                add_txn(acdd_pkg::FUNC_PUSH, 8'($urandom), 16'($urandom), 8'($urandom));
            else if (dec_qcnt < QDEPTH && r < 55)
                add_txn(acdd_pkg::FUNC_PUSH, 8'($urandom), 16'($urandom), 8'($urandom));
            else add_txn(acdd_pkg::FUNC_PULL, 8'($urandom), 16'($urandom), 8'($urandom));
            budget--;
            // cut long streams short now and then
            if ($urandom_range(0, 999) == 0) break;
        end
        if ($urandom_range(0, 9) == 0) begin
            add_txn(acdd_pkg::FUNC_PULL, 8'($urandom), 16'($urandom), 8'($urandom));
            budget--;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int budget;
        logic [7:0] hdr [5];
        clear_decoder();
        // no stream yet, unused func code, zero-length start
        add_txn(acdd_pkg::FUNC_PULL, 8'h00, 16'h0000, 8'h00);
        add_txn(acdd_pkg::FUNC_PUSH, 8'hFF, 16'hFFFF, 8'hFF);
        add_txn(FUNC_NONE, 8'hA5, 16'h1234, 8'h5A);
        add_txn(acdd_pkg::FUNC_START, 8'h00, 16'd0, 8'd3);
        add_txn(acdd_pkg::FUNC_PULL, 8'h00, 16'd0, 8'd0);
        // one short stream per header mode: zero, repeat, keys, 2-bit and 14-bit deltas
        hdr = '{8'h10, 8'hFE, 8'h1F, 8'h21, 8'hFD};
        foreach (hdr[m]) begin
            add_txn(acdd_pkg::FUNC_START, 8'h00, 16'd5, (m == 0) ? 8'd0 : 8'd255);
            add_txn(acdd_pkg::FUNC_PULL, 8'h00, 16'd0, 8'd0);   // header not there yet
            add_txn(acdd_pkg::FUNC_PUSH, hdr[m], 16'd0, 8'd0);
            add_txn(acdd_pkg::FUNC_PUSH, 8'hFF, 16'd0, 8'd0);
            add_txn(acdd_pkg::FUNC_PUSH, 8'h80, 16'd0, 8'd0);
            add_txn(acdd_pkg::FUNC_PUSH, 8'hC3, 16'd0, 8'd0);
            add_txn(acdd_pkg::FUNC_PUSH, 8'h3C, 16'd0, 8'd0);   // queue full
            for (int i = 0; i < 6; i++) begin
                add_txn(acdd_pkg::FUNC_PULL, 8'h00, 16'd0, 8'd0);
                add_txn(acdd_pkg::FUNC_PUSH, 8'($urandom), 16'd0, 8'd0);
            end
        end
        budget = 1900;
        while (budget > 0) random_stream(budget);
        stim_done = 1'b1;
    end

    // ------------------------------------------------------------------
    // Driver: one transaction at a time from the pending queue
    // ------------------------------------------------------------------
    function automatic bit idle_roll();
        // quiet stretch with no idling on either side
        if (cycle_cnt > 3000 && cycle_cnt < 9000) return 1'b0;
        return $urandom_range(0, 99) < 11;
    endfunction

    always @(posedge i_clk) begin
        t_txn t;
        cycle_cnt <= cycle_cnt + 1;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_stall) begin
            // hold the stalled transaction
        end else if (pending_txns.size() != 0 && !idle_roll()) begin
            t = pending_txns.pop_front();
            i_in_valid <= 1'b1;
            i_func <= t.func;
            i_data_byte <= t.data;
            i_stream_length <= t.len;
            i_step_size <= t.step;
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each accepted result with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_sample_res exp_r;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_samples.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: status %0d sample %0d", o_status, o_sample);
                end else begin
                    exp_r = expected_samples.pop_front();
                    if (o_status !== exp_r.status || o_sample !== exp_r.sample ||
                        o_dest_offset !== exp_r.offset || o_last_sample !== exp_r.last ||
                        o_bytes_used !== exp_r.used) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                                     exp_r.status, exp_r.sample, exp_r.offset, exp_r.last,
                                     exp_r.used, o_status, o_sample, o_dest_offset,
                                     o_last_sample, o_bytes_used);
                    end
                end
            end
            i_out_stall <= idle_roll();
        end
    end

    // ------------------------------------------------------------------
    // Reset, drain and verdict
    // ------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (!stim_done || pending_txns.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (expected_samples.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (mismatches == 0 && expected_samples.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #4ms;
        $display("FAILURE");
        $finish;
    end

endmodule
